FILE: design/rcfa_pkg.sv
// ----------------------------------------------------------------------------
// rcfa_pkg
// Shared constants, register numbers and types for the CSR file access block.
// ----------------------------------------------------------------------------
package rcfa_pkg;

	localparam int REG_COUNT_DEF = 122;
	localparam int IDX_W         = 7;
	localparam int XLEN          = 64;
	localparam int HART_W        = 12;
	localparam int NPC_W         = 3;
	localparam int IN_DATA_W     = 208;
	localparam int OUT_DATA_W    = 72;

	localparam logic [IDX_W-1:0] R_PRV        = 7'd0;
	localparam logic [IDX_W-1:0] R_ISA        = 7'd1;
	localparam logic [IDX_W-1:0] R_HARTID     = 7'd5;
	localparam logic [IDX_W-1:0] R_STATUS     = 7'd6;
	localparam logic [IDX_W-1:0] R_CYCLE      = 7'd9;
	localparam logic [IDX_W-1:0] R_TIME       = 7'd10;
	localparam logic [IDX_W-1:0] R_INSTRET    = 7'd11;
	localparam logic [IDX_W-1:0] R_HPM31      = 7'd40;
	localparam logic [IDX_W-1:0] R_TSELECT    = 7'd70;
	localparam logic [IDX_W-1:0] R_MCOUNTEREN = 7'd80;
	localparam logic [IDX_W-1:0] R_MEPC       = 7'd82;
	localparam logic [IDX_W-1:0] R_PMPCFG0    = 7'd85;
	localparam logic [IDX_W-1:0] R_PMPADDR15  = 7'd102;
	localparam logic [IDX_W-1:0] R_SCOUNTEREN = 7'd106;
	localparam logic [IDX_W-1:0] R_SEPC       = 7'd108;
	localparam logic [IDX_W-1:0] R_SATP       = 7'd111;
	localparam logic [IDX_W-1:0] R_FFLAGS     = 7'd117;
	localparam logic [IDX_W-1:0] R_FRM        = 7'd118;
	localparam logic [IDX_W-1:0] R_NMIE       = 7'd120;

	localparam logic [XLEN-1:0] PRV_MACHINE    = 64'd3;
	localparam logic [XLEN-1:0] PRV_SUPERVISOR = 64'd1;
	localparam logic [XLEN-1:0] PRV_USER       = 64'd0;

	localparam logic [XLEN-1:0] ISA_RESET    = (64'd2 << 62) | 64'h14112D;
	localparam logic [XLEN-1:0] STATUS_RESET = (64'd2 << 32) | (64'd2 << 34) | (64'd1 << 13);
	localparam logic [XLEN-1:0] CNTEN_RESET  = 64'h7;
	localparam logic [XLEN-1:0] STATUS_FS_SD = (64'd3 << 13) | (64'd1 << 63);

	localparam logic [3:0] SATP_BARE = 4'd0;
	localparam logic [3:0] SATP_SV39 = 4'd8;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	function automatic logic [XLEN-1:0] reset_value(input logic [IDX_W-1:0] idx);
		logic [XLEN-1:0] v;
		v = '0;
		unique case (idx)
			R_PRV:        v = PRV_MACHINE;
			R_ISA:        v = ISA_RESET;
			R_STATUS:     v = STATUS_RESET;
			R_MCOUNTEREN: v = CNTEN_RESET;
			R_SCOUNTEREN: v = CNTEN_RESET;
			R_TSELECT:    v = 64'd1;
			R_NMIE:       v = 64'd1;
			default:      v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: design/riscv_csr_file_access.sv
// ----------------------------------------------------------------------------
// riscv_csr_file_access
// Control and status register file: one read or write per item, with the
// counter gating, address masking and write side effects of the privileged
// architecture, over a synchronous register memory.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake              Payload
// s_axis   in   s_axis_tvalid/tready   tdata: index, write data, counts, pc low
//                                      tuser: action
// m_axis   out  m_axis_tvalid/tready   tdata: read data, tlb flush
//                                      tuser: illegal
// cfg      in   cfg_valid/cfg_ready    cfg_data: hart id
//
// An item is handled in steps: the memory read on acceptance, then the
// read-modify-write and the result register load. The single-ported
// register memory sets that split. A result waits in the output register
// while the next item is taken; the execute step stalls only when that
// register is still full. Reset takes effect at once through per-entry
// valid bits; there is no clearing pass.
// ----------------------------------------------------------------------------
module riscv_csr_file_access #(
	parameter int REG_COUNT = rcfa_pkg::REG_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [6:0] reg_index, [70:7] write_data, [134:71] cycle_count,
	// [198:135] instret_count, [201:199] next_pc_low, rest zero
	input  logic [rcfa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// [0] action
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [63:0] read_data, [64] tlb_flush, rest zero
	output logic [rcfa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// [0] illegal
	output logic                              m_axis_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rcfa_pkg::HART_W-1:0]       cfg_data
);
	import rcfa_pkg::*;

	localparam int AW = $clog2(REG_COUNT);

	state_t state_q, state_d;

	logic [XLEN-1:0] mem [REG_COUNT];
	logic [REG_COUNT-1:0] valid_q;

	logic [HART_W-1:0] hart_id_q;
	logic [XLEN-1:0] prv_q, isa_q, status_q, mcen_q, scen_q;

	logic             act_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [XLEN-1:0]  wdata_s1, cyc_s1, inst_s1, rd_data_s1;
	logic [NPC_W-1:0] npc_s1;
	logic             vld_s1;

	logic             out_valid_q;
	logic [XLEN-1:0]  out_data_q;
	logic             out_ill_q, out_flush_q;

	logic             accept, fire, rd_en, in_range_in;
	logic [IDX_W-1:0] idx_in;

	logic [XLEN-1:0] stored, cur, rdv, wv;
	logic            in_range, is_cnt, is_pmp, reg_held, wr_en, res_ill, res_flush;
	logic            gate_en, gate_bad;
	logic [4:0]      cnt_bit;
	logic [IDX_W-1:0] cnt_off;
	logic [XLEN-1:0] cnt_val;

	assign idx_in      = s_axis_tdata[6:0];
	assign in_range_in = {1'b0, idx_in} < 8'(REG_COUNT);
	assign accept      = s_axis_tvalid && s_axis_tready;
	assign cfg_ready   = 1'b1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_EXEC;
			ST_EXEC: if (fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		fire          = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_EXEC: fire = !out_valid_q || m_axis_tready;
			default: s_axis_tready = 1'b0;
		endcase
		rd_en = accept && in_range_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && wr_en && !reg_held) begin
			mem[idx_s1[AW-1:0]] <= wv;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[idx_in[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (fire && wr_en && !reg_held) begin
			valid_q[idx_s1[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1   <= s_axis_tuser;
			idx_s1   <= idx_in;
			wdata_s1 <= s_axis_tdata[70:7];
			cyc_s1   <= s_axis_tdata[134:71];
			inst_s1  <= s_axis_tdata[198:135];
			npc_s1   <= s_axis_tdata[201:199];
			vld_s1   <= in_range_in && valid_q[idx_in[AW-1:0]];
		end
	end

	always_comb begin
		in_range = {1'b0, idx_s1} < 8'(REG_COUNT);
		is_cnt   = idx_s1 >= R_CYCLE && idx_s1 <= R_HPM31;
		is_pmp   = idx_s1 >= R_PMPCFG0 && idx_s1 <= R_PMPADDR15;
		stored   = vld_s1 ? rd_data_s1 : reset_value(idx_s1);
		reg_held = 1'b1;
		unique case (idx_s1)
			R_PRV:        cur = prv_q;
			R_ISA:        cur = isa_q;
			R_STATUS:     cur = status_q;
			R_MCOUNTEREN: cur = mcen_q;
			R_SCOUNTEREN: cur = scen_q;
			default: begin
				cur      = stored;
				reg_held = 1'b0;
			end
		endcase

		cnt_off  = idx_s1 - R_CYCLE;
		cnt_bit  = cnt_off[4:0];
		gate_en  = 1'b0;
		gate_bad = 1'b0;
		if (prv_q == PRV_MACHINE) begin
			gate_en = 1'b1;
		end else if (prv_q == PRV_SUPERVISOR) begin
			gate_en = mcen_q[cnt_bit];
		end else if (prv_q == PRV_USER) begin
			gate_en = scen_q[cnt_bit];
		end else begin
			gate_bad = 1'b1;
		end
		if (idx_s1 == R_INSTRET) begin
			cnt_val = inst_s1;
		end else if (idx_s1 == R_TIME) begin
			cnt_val = cur;
		end else begin
			cnt_val = cyc_s1;
		end

		rdv       = '0;
		wv        = wdata_s1;
		wr_en     = 1'b0;
		res_ill   = 1'b0;
		res_flush = 1'b0;
		if (!in_range) begin
			res_ill = 1'b1;
		end else if (!act_s1) begin
			if (idx_s1 == R_HARTID) begin
				rdv = XLEN'(hart_id_q);
			end else if (is_cnt) begin
				if (gate_bad) begin
					res_ill = 1'b1;
				end else if (gate_en) begin
					rdv = cnt_val;
				end
			end else if (idx_s1 == R_MEPC || idx_s1 == R_SEPC) begin
				rdv = isa_q[2] ? (cur & ~64'd1) : (cur & ~64'd3);
			end else begin
				rdv = cur;
			end
		end else if (is_cnt) begin
			wr_en = 1'b0;
		end else if (is_pmp) begin
			wr_en   = prv_q == PRV_MACHINE;
			res_ill = prv_q != PRV_MACHINE;
		end else begin
			wr_en = 1'b1;
			if (idx_s1 == R_SATP) begin
				if (wdata_s1[63:60] != SATP_BARE && wdata_s1[63:60] != SATP_SV39) begin
					wv = {cur[63:60], wdata_s1[59:0]};
				end
				res_flush = cur != wv;
			end else if (idx_s1 == R_TSELECT) begin
				wv = wdata_s1 + 64'd1;
			end else if (idx_s1 == R_ISA) begin
				if (!wdata_s1[2] && npc_s1 != '0) begin
					wv[2] = cur[2];
				end
			end else if (idx_s1 == R_STATUS) begin
				wv = {wdata_s1[14:13] == 2'b11, wdata_s1[62:36], cur[35:32],
					wdata_s1[31:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hart_id_q <= '0;
			prv_q     <= PRV_MACHINE;
			isa_q     <= ISA_RESET;
			status_q  <= STATUS_RESET;
			mcen_q    <= CNTEN_RESET;
			scen_q    <= CNTEN_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				hart_id_q <= cfg_data;
			end
			if (fire && wr_en) begin
				case (idx_s1)
					R_PRV:        prv_q <= wv;
					R_ISA:        isa_q <= wv;
					R_STATUS:     status_q <= wv;
					R_MCOUNTEREN: mcen_q <= wv;
					R_SCOUNTEREN: scen_q <= wv;
					R_FFLAGS, R_FRM: status_q <= status_q | STATUS_FS_SD;
					default:      prv_q <= prv_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q  <= rdv;
			out_ill_q   <= res_ill;
			out_flush_q <= res_flush;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_flush_q, out_data_q};
	assign m_axis_tuser  = out_ill_q;

endmodule

FILE: design/rcfa_checker.sv
// ----------------------------------------------------------------------------
// rcfa_checker
// Port-level checks for the CSR file access block, bound to its top level.
// ----------------------------------------------------------------------------
module rcfa_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [rcfa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tuser
);
	import rcfa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("Result item dropped while stalled.");

	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("Input item taken during the execute cycle.");

	a_ill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[XLEN:0] == '0)
		else $error("Illegal access returned data or a flush.");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:XLEN+1] == '0)
		else $error("Result padding bits are not zero.");

endmodule

bind riscv_csr_file_access rcfa_checker u_rcfa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
